/* design/lbpc_pkg.sv */
// ----------------------------------------------------------------------------
// lbpc_pkg
// Types and constants for the lamp button and battery power controller.
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATT_LOW  = 3'd0,
        CFG_BATT_OFF  = 3'd1,
        CFG_SHORT     = 3'd2,
        CFG_LONG      = 3'd3,
        CFG_BATT_HOLD = 3'd4
    } cfg_idx_t;

    localparam logic [LEVEL_W-1:0] RST_BATT_LOW  = 10'd363;
    localparam logic [LEVEL_W-1:0] RST_BATT_OFF  = 10'd388;
    localparam logic [TICK_W-1:0]  RST_SHORT     = 16'd30;
    localparam logic [TICK_W-1:0]  RST_LONG      = 16'd500;
    localparam logic [TICK_W-1:0]  RST_BATT_HOLD = 16'd5000;

    typedef enum logic [STATE_W-1:0] {
        ST_WORK  = 3'd0,
        ST_HELD  = 3'd1,
        ST_WAIT  = 3'd2,
        ST_SLEEP = 3'd3,
        ST_WOKEN = 3'd4
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE         = 3'd0,
        CMD_ON           = 3'd1,
        CMD_FLICKER      = 3'd2,
        CMD_FADE         = 3'd3,
        CMD_BLINK1       = 3'd4,
        CMD_BLINK2       = 3'd5,
        CMD_SLEEP        = 3'd6,
        CMD_FLICKER_FADE = 3'd7
    } led_cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] battery_low_level;
        logic [LEVEL_W-1:0] battery_off_level;
        logic [TICK_W-1:0]  short_press_ticks;
        logic [TICK_W-1:0]  long_press_ticks;
        logic [TICK_W-1:0]  battery_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic               key_pressed;
        logic               sample_valid;
        logic [LEVEL_W-1:0] battery_reading;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]   led_command;
        logic [STATE_W-1:0] power_state;
        logic               lock_active;
    } out_item_t;

endpackage

/* design/lbpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lbpc_cfg_regs
// Configuration register file: levels and tick thresholds.
// ----------------------------------------------------------------------------
module lbpc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [lbpc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [lbpc_pkg::CFG_DATA_W-1:0]   wr_data,
    output lbpc_pkg::cfg_t                    cfg
);

    lbpc_pkg::cfg_t cfg_reg;
    lbpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lbpc_pkg::CFG_BATT_LOW:
                    cfg_next.battery_low_level  = wr_data[lbpc_pkg::LEVEL_W-1:0];
                lbpc_pkg::CFG_BATT_OFF:
                    cfg_next.battery_off_level  = wr_data[lbpc_pkg::LEVEL_W-1:0];
                lbpc_pkg::CFG_SHORT:
                    cfg_next.short_press_ticks  = wr_data[lbpc_pkg::TICK_W-1:0];
                lbpc_pkg::CFG_LONG:
                    cfg_next.long_press_ticks   = wr_data[lbpc_pkg::TICK_W-1:0];
                lbpc_pkg::CFG_BATT_HOLD:
                    cfg_next.battery_hold_ticks = wr_data[lbpc_pkg::TICK_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.battery_low_level  <= lbpc_pkg::RST_BATT_LOW;
            cfg_reg.battery_off_level  <= lbpc_pkg::RST_BATT_OFF;
            cfg_reg.short_press_ticks  <= lbpc_pkg::RST_SHORT;
            cfg_reg.long_press_ticks   <= lbpc_pkg::RST_LONG;
            cfg_reg.battery_hold_ticks <= lbpc_pkg::RST_BATT_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/lbpc_core.sv */
// ----------------------------------------------------------------------------
// lbpc_core
// Power state machine, lock flag and saturating tick timers; one step per item.
// ----------------------------------------------------------------------------
module lbpc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lbpc_pkg::in_item_t   item,
    input  lbpc_pkg::cfg_t       cfg,
    output lbpc_pkg::out_item_t  result
);

    lbpc_pkg::mode_t            mode_reg, mode_next;
    logic                       lock_reg, lock_next;
    logic [lbpc_pkg::TICK_W-1:0] press_reg, press_next;
    logic [lbpc_pkg::TICK_W-1:0] low_reg, low_next;
    logic [lbpc_pkg::TICK_W-1:0] dead_reg, dead_next;

    logic [lbpc_pkg::TICK_W-1:0] press_inc, low_inc, dead_inc;
    logic                        low_hit, off_hit, flick, fade;
    lbpc_pkg::led_cmd_t          cmd;

    assign press_inc = (press_reg == lbpc_pkg::TICK_MAX) ? press_reg : press_reg + 1'b1;
    assign low_inc   = (low_reg == lbpc_pkg::TICK_MAX) ? low_reg : low_reg + 1'b1;
    assign dead_inc  = (dead_reg == lbpc_pkg::TICK_MAX) ? dead_reg : dead_reg + 1'b1;

    assign low_hit = item.battery_reading > cfg.battery_low_level;
    assign off_hit = item.battery_reading > cfg.battery_off_level;
    assign flick   = low_hit && (low_inc > cfg.battery_hold_ticks);
    assign fade    = off_hit && (dead_inc > cfg.battery_hold_ticks);

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            lbpc_pkg::ST_WORK:
            begin
                if (item.key_pressed)
                    mode_next = lbpc_pkg::ST_HELD;
                else if (item.sample_valid && fade)
                    mode_next = lbpc_pkg::ST_WAIT;
            end
            lbpc_pkg::ST_HELD:
            begin
                if (item.key_pressed)
                begin
                    if (press_inc > cfg.long_press_ticks)
                        mode_next = lbpc_pkg::ST_WAIT;
                end
                else if (press_inc > cfg.short_press_ticks)
                    mode_next = lbpc_pkg::ST_WAIT;
                else
                    mode_next = lbpc_pkg::ST_WORK;
            end
            lbpc_pkg::ST_SLEEP:
            begin
                if (item.key_pressed)
                    mode_next = lbpc_pkg::ST_WOKEN;
            end
            lbpc_pkg::ST_WOKEN:
            begin
                if (item.key_pressed)
                begin
                    if (press_inc > cfg.long_press_ticks)
                        mode_next = lbpc_pkg::ST_WAIT;
                end
                else if (press_inc > cfg.short_press_ticks && !lock_reg)
                    mode_next = lbpc_pkg::ST_WORK;
                else
                    mode_next = lbpc_pkg::ST_WAIT;
            end
            default:
            begin
                mode_next = item.key_pressed ? lbpc_pkg::ST_WAIT : lbpc_pkg::ST_SLEEP;
            end
        endcase
    end

    // command, lock and timers
    always_comb
    begin
        cmd        = lbpc_pkg::CMD_NONE;
        lock_next  = lock_reg;
        press_next = press_inc;
        low_next   = low_inc;
        dead_next  = dead_inc;
        unique case (mode_reg)
            lbpc_pkg::ST_WORK:
            begin
                if (item.key_pressed)
                    press_next = '0;
                else if (item.sample_valid)
                begin
                    if (!low_hit || flick)
                        low_next = '0;
                    if (!off_hit || fade)
                        dead_next = '0;
                    if (flick && fade)
                        cmd = lbpc_pkg::CMD_FLICKER_FADE;
                    else if (flick)
                        cmd = lbpc_pkg::CMD_FLICKER;
                    else if (fade)
                        cmd = lbpc_pkg::CMD_FADE;
                end
            end
            lbpc_pkg::ST_HELD:
            begin
                if (item.key_pressed)
                begin
                    if (press_inc > cfg.long_press_ticks)
                        cmd = lbpc_pkg::CMD_FADE;
                end
                else if (press_inc > cfg.short_press_ticks)
                    cmd = lbpc_pkg::CMD_FADE;
            end
            lbpc_pkg::ST_SLEEP:
            begin
                if (item.key_pressed)
                begin
                    press_next = '0;
                    low_next   = '0;
                    dead_next  = '0;
                end
            end
            lbpc_pkg::ST_WOKEN:
            begin
                if (item.key_pressed)
                begin
                    if (press_inc > cfg.long_press_ticks)
                    begin
                        press_next = '0;
                        lock_next  = !lock_reg;
                        cmd = lock_reg ? lbpc_pkg::CMD_BLINK2 : lbpc_pkg::CMD_BLINK1;
                    end
                end
                else if (press_inc > cfg.short_press_ticks && !lock_reg)
                begin
                    press_next = '0;
                    cmd        = lbpc_pkg::CMD_ON;
                end
            end
            default:
            begin
                if (!item.key_pressed)
                    cmd = lbpc_pkg::CMD_SLEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lbpc_pkg::ST_WAIT;
            lock_reg  <= 1'b0;
            press_reg <= '0;
            low_reg   <= '0;
            dead_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            lock_reg  <= lock_next;
            press_reg <= press_next;
            low_reg   <= low_next;
            dead_reg  <= dead_next;
        end
    end

    assign result.led_command = cmd;
    assign result.power_state = mode_next;
    assign result.lock_active = lock_next;

endmodule

/* design/lamp_button_power_controller.sv */
// ----------------------------------------------------------------------------
// lamp_button_power_controller
// Lamp power controller: one input item per tick, one LED command per item.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the output side does not stall. Each
// item is loaded into the input register and stepped through the
// single-step state machine, and its result is loaded into the output
// register. A stall on the output side holds the input register and then
// the input side.
module lamp_button_power_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lbpc_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lbpc_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lbpc_pkg::cfg_t       cfg;
    lbpc_pkg::in_item_t   in_data_reg;
    logic                 in_valid_reg;
    lbpc_pkg::out_item_t  out_data_reg;
    logic                 out_valid_reg;
    lbpc_pkg::out_item_t  result;
    logic                 advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;

    lbpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lbpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/lbpc_checker.sv */
// ----------------------------------------------------------------------------
// lbpc_checker
// Port-level checks on the lamp power controller, bound to the top level.
// ----------------------------------------------------------------------------
module lbpc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  lbpc_pkg::out_item_t  out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.power_state <= lbpc_pkg::ST_WOKEN)
        else $error("power state out of range");

    a_blink_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.led_command == lbpc_pkg::CMD_BLINK1 ||
                      out_data.led_command == lbpc_pkg::CMD_BLINK2)
        |-> out_data.lock_active == (out_data.led_command == lbpc_pkg::CMD_BLINK1)
            && out_data.power_state == lbpc_pkg::ST_WAIT)
        else $error("blink does not match lock");

    a_on_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.led_command == lbpc_pkg::CMD_ON
        |-> !out_data.lock_active && out_data.power_state == lbpc_pkg::ST_WORK)
        else $error("turned on while locked or not working");

    a_sleep_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.led_command == lbpc_pkg::CMD_SLEEP
        |-> out_data.power_state == lbpc_pkg::ST_SLEEP)
        else $error("sleep command without sleep state");

endmodule

bind lamp_button_power_controller lbpc_checker u_lbpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
